[hw/rtl/dtfe_pkg.sv]
// ----------------------------------------------------------------------------
// dtfe_pkg
// Shared types and constants of the decimal telemetry frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dtfe_pkg;

  typedef logic [7:0] byte_t;

  // Fixed frame bytes.
  localparam byte_t HEADER_BYTE  = 8'hFF;
  localparam byte_t SEP_BYTE     = 8'h00;
  localparam byte_t TRAILER_BYTE = 8'hEE;

  localparam int FRAME_LEN = 21;
  localparam int CNT_W     = $clog2(FRAME_LEN + 1);

  // Frame positions of the three separators.
  localparam int SEP0_POS = 5;
  localparam int SEP1_POS = 10;
  localparam int SEP2_POS = 15;

  // Reciprocal constants: q = (v * MUL) >> SHIFT is exact over the value range
  // that each divider stage sees.
  localparam int DIV_1000   = 1000;
  localparam int MUL_1000   = 67109;  // exact for v < 65536
  localparam int SHIFT_1000 = 26;
  localparam int DIV_100    = 100;
  localparam int MUL_100    = 41;     // exact for v < 1000
  localparam int SHIFT_100  = 12;
  localparam int DIV_10     = 10;
  localparam int MUL_10     = 205;    // exact for v < 1029
  localparam int SHIFT_10   = 11;

  // Latency of one digit cell, in cycles.
  localparam int CELL_LAT = 2;
  // Depth of the conversion pipeline: three digit cells in a row.
  localparam int CONV_LAT = 3 * CELL_LAT;

  // Control that every byte cell of the frame chain receives.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage : dtfe_pkg

`default_nettype wire

[hw/rtl/dtfe_if.sv]
// ----------------------------------------------------------------------------
// dtfe_req_if / dtfe_frame_if
// Valid/ready channels for report requests and for frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtfe_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  humidity_whole;
  logic [7:0]  humidity_fraction;
  logic [7:0]  temperature_whole;
  logic [7:0]  temperature_fraction;
  logic [15:0] smoke_level;
  logic [15:0] light_level;

  modport source (
    output valid, humidity_whole, humidity_fraction, temperature_whole,
           temperature_fraction, smoke_level, light_level,
    input  ready
  );
  modport sink (
    input  valid, humidity_whole, humidity_fraction, temperature_whole,
           temperature_fraction, smoke_level, light_level,
    output ready
  );
endinterface : dtfe_req_if

interface dtfe_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (
    output valid, frame_byte, frame_end,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, frame_end,
    output ready
  );
endinterface : dtfe_frame_if

`default_nettype wire

[hw/rtl/dtfe_digit_cell.sv]
// ----------------------------------------------------------------------------
// dtfe_digit_cell
// One decimal divider cell: splits a value into quotient and remainder by a
// constant divisor over two registered steps.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfe_digit_cell #(
  parameter int IN_W  = 16,
  parameter int DIV   = 1000,
  parameter int MUL   = 67109,
  parameter int SHIFT = 26,
  parameter int REM_W = $clog2(DIV)
) (
  input  wire                  clk_i,
  input  wire                  en_i,
  input  wire [IN_W-1:0]       value_i,
  output dtfe_pkg::byte_t      digit_o,
  output logic [REM_W-1:0]     rem_o
);
  import dtfe_pkg::*;

  localparam int MUL_W  = $clog2(MUL + 1);
  localparam int PROD_W = IN_W + MUL_W;

  logic [PROD_W-1:0] prod;
  logic [IN_W-1:0]   value_q;
  byte_t             quot_q;
  logic [IN_W-1:0]   rem_full;
  byte_t             digit_q;
  logic [REM_W-1:0]  rem_q;

  assign prod     = PROD_W'(value_i) * PROD_W'(MUL);
  assign rem_full = value_q - IN_W'(32'(quot_q) * DIV);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_i;
      quot_q  <= 8'(prod >> SHIFT);
      digit_q <= quot_q;
      rem_q   <= REM_W'(rem_full);
    end
  end

  assign digit_o = digit_q;
  assign rem_o   = rem_q;

endmodule : dtfe_digit_cell

`default_nettype wire

[hw/rtl/dtfe_byte_cell.sv]
// ----------------------------------------------------------------------------
// dtfe_byte_cell
// One byte of the frame chain: loads in parallel, or takes its neighbor's
// byte when the chain shifts toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfe_byte_cell (
  input  wire                  clk_i,
  input  dtfe_pkg::cell_ctrl_t ctrl_i,
  input  dtfe_pkg::byte_t      load_byte_i,
  input  dtfe_pkg::byte_t      next_byte_i,
  output dtfe_pkg::byte_t      byte_o
);
  import dtfe_pkg::*;

  byte_t byte_d, byte_q;

  // A load wins over a shift: the new frame replaces the last byte just sent.
  always_comb begin
    priority if (ctrl_i.load) begin
      byte_d = load_byte_i;
    end else if (ctrl_i.shift) begin
      byte_d = next_byte_i;
    end else begin
      byte_d = byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule : dtfe_byte_cell

`default_nettype wire

[hw/rtl/decimal_telemetry_frame_encoder_core.sv]
// ----------------------------------------------------------------------------
// decimal_telemetry_frame_encoder_core
// Turns one report request of six readings into a 21-byte decimal frame.
// ----------------------------------------------------------------------------
// Each accepted request becomes 21 words on the frame channel: header 0xFF,
// humidity and temperature as tens/ones bytes, smoke and light as four digit
// bytes, 0x00 separators and the trailer 0xEE, which alone carries frame_end.
// The readings pass through a row of constant divider cells and are then
// loaded into a 21-cell byte chain that shifts one word out per cycle while
// the frame channel is ready. The byte chain sets the pace of requests; the
// divider row takes and holds the next request while the current frame
// drains, so consecutive frames follow without a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_telemetry_frame_encoder_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  dtfe_req_if.sink     req_i,
  dtfe_frame_if.source frame_o
);
  import dtfe_pkg::*;

  localparam int RAW_DLY = CONV_LAT - CELL_LAT;  // 8-bit values enter late
  localparam int TH_DLY  = CONV_LAT - CELL_LAT;  // thousands digit wait
  localparam int H_DLY   = CELL_LAT;             // hundreds digit wait

  logic [CONV_LAT-1:0] vld_d, vld_q;
  logic [CNT_W-1:0]    cnt_d, cnt_q;
  logic                en, load, in_fire, out_fire;
  cell_ctrl_t          ctrl;

  logic [31:0] raw8_q [RAW_DLY];
  byte_t       sk_th_q [TH_DLY];
  byte_t       lt_th_q [TH_DLY];
  byte_t       sk_h_q  [H_DLY];
  byte_t       lt_h_q  [H_DLY];

  byte_t       sk_th, sk_h, sk_t, lt_th, lt_h, lt_t;
  logic [9:0]  sk_r1000, lt_r1000;
  logic [6:0]  sk_r100, lt_r100;
  logic [3:0]  sk_o, lt_o;
  byte_t       hw_t, hf_t, tw_t, tf_t;
  logic [3:0]  hw_o, hf_o, tw_o, tf_o;

  byte_t       frame_bytes [FRAME_LEN];
  byte_t       chain_q     [FRAME_LEN];

  // The last divider stage holds its result until the byte chain can load it.
  assign load     = vld_q[CONV_LAT-1] &&
                    ((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_fire));
  assign en       = !vld_q[CONV_LAT-1] || load;
  assign in_fire  = req_i.valid && req_i.ready;
  assign out_fire = frame_o.valid && frame_o.ready;
  assign req_i.ready = en;

  assign vld_d = en ? {vld_q[CONV_LAT-2:0], in_fire} : vld_q;

  always_comb begin
    cnt_d = cnt_q;
    priority if (load) begin
      cnt_d = CNT_W'(FRAME_LEN);
    end else if (out_fire) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  // Alignment registers that keep early digits and late inputs in step.
  always_ff @(posedge clk_i) begin
    if (en) begin
      raw8_q[0] <= {req_i.humidity_whole, req_i.humidity_fraction,
                    req_i.temperature_whole, req_i.temperature_fraction};
      for (int i = 1; i < RAW_DLY; i++) begin
        raw8_q[i] <= raw8_q[i-1];
      end
      sk_th_q[0] <= sk_th;
      lt_th_q[0] <= lt_th;
      for (int i = 1; i < TH_DLY; i++) begin
        sk_th_q[i] <= sk_th_q[i-1];
        lt_th_q[i] <= lt_th_q[i-1];
      end
      sk_h_q[0] <= sk_h;
      lt_h_q[0] <= lt_h;
      for (int i = 1; i < H_DLY; i++) begin
        sk_h_q[i] <= sk_h_q[i-1];
        lt_h_q[i] <= lt_h_q[i-1];
      end
    end
  end

  // Smoke lane: thousands, hundreds, tens cells in a row.
  dtfe_digit_cell #(.IN_W(16), .DIV(DIV_1000), .MUL(MUL_1000), .SHIFT(SHIFT_1000))
    u_sk_th (.clk_i, .en_i(en), .value_i(req_i.smoke_level),
             .digit_o(sk_th), .rem_o(sk_r1000));
  dtfe_digit_cell #(.IN_W(10), .DIV(DIV_100), .MUL(MUL_100), .SHIFT(SHIFT_100))
    u_sk_h (.clk_i, .en_i(en), .value_i(sk_r1000), .digit_o(sk_h), .rem_o(sk_r100));
  dtfe_digit_cell #(.IN_W(7), .DIV(DIV_10), .MUL(MUL_10), .SHIFT(SHIFT_10))
    u_sk_t (.clk_i, .en_i(en), .value_i(sk_r100), .digit_o(sk_t), .rem_o(sk_o));

  // Light lane.
  dtfe_digit_cell #(.IN_W(16), .DIV(DIV_1000), .MUL(MUL_1000), .SHIFT(SHIFT_1000))
    u_lt_th (.clk_i, .en_i(en), .value_i(req_i.light_level),
             .digit_o(lt_th), .rem_o(lt_r1000));
  dtfe_digit_cell #(.IN_W(10), .DIV(DIV_100), .MUL(MUL_100), .SHIFT(SHIFT_100))
    u_lt_h (.clk_i, .en_i(en), .value_i(lt_r1000), .digit_o(lt_h), .rem_o(lt_r100));
  dtfe_digit_cell #(.IN_W(7), .DIV(DIV_10), .MUL(MUL_10), .SHIFT(SHIFT_10))
    u_lt_t (.clk_i, .en_i(en), .value_i(lt_r100), .digit_o(lt_t), .rem_o(lt_o));

  // The 8-bit readings run beside the last cell of the 16-bit lanes.
  dtfe_digit_cell #(.IN_W(8), .DIV(DIV_10), .MUL(MUL_10), .SHIFT(SHIFT_10))
    u_hw (.clk_i, .en_i(en), .value_i(raw8_q[RAW_DLY-1][31:24]),
          .digit_o(hw_t), .rem_o(hw_o));
  dtfe_digit_cell #(.IN_W(8), .DIV(DIV_10), .MUL(MUL_10), .SHIFT(SHIFT_10))
    u_hf (.clk_i, .en_i(en), .value_i(raw8_q[RAW_DLY-1][23:16]),
          .digit_o(hf_t), .rem_o(hf_o));
  dtfe_digit_cell #(.IN_W(8), .DIV(DIV_10), .MUL(MUL_10), .SHIFT(SHIFT_10))
    u_tw (.clk_i, .en_i(en), .value_i(raw8_q[RAW_DLY-1][15:8]),
          .digit_o(tw_t), .rem_o(tw_o));
  dtfe_digit_cell #(.IN_W(8), .DIV(DIV_10), .MUL(MUL_10), .SHIFT(SHIFT_10))
    u_tf (.clk_i, .en_i(en), .value_i(raw8_q[RAW_DLY-1][7:0]),
          .digit_o(tf_t), .rem_o(tf_o));

  always_comb begin
    frame_bytes[0]        = HEADER_BYTE;
    frame_bytes[1]        = hw_t;
    frame_bytes[2]        = 8'(hw_o);
    frame_bytes[3]        = hf_t;
    frame_bytes[4]        = 8'(hf_o);
    frame_bytes[SEP0_POS] = SEP_BYTE;
    frame_bytes[6]        = tw_t;
    frame_bytes[7]        = 8'(tw_o);
    frame_bytes[8]        = tf_t;
    frame_bytes[9]        = 8'(tf_o);
    frame_bytes[SEP1_POS] = SEP_BYTE;
    frame_bytes[11]       = sk_th_q[TH_DLY-1];
    frame_bytes[12]       = sk_h_q[H_DLY-1];
    frame_bytes[13]       = sk_t;
    frame_bytes[14]       = 8'(sk_o);
    frame_bytes[SEP2_POS] = SEP_BYTE;
    frame_bytes[16]       = lt_th_q[TH_DLY-1];
    frame_bytes[17]       = lt_h_q[H_DLY-1];
    frame_bytes[18]       = lt_t;
    frame_bytes[19]       = 8'(lt_o);
    frame_bytes[20]       = TRAILER_BYTE;
  end

  assign ctrl.load  = load;
  assign ctrl.shift = out_fire;

  for (genvar i = 0; i < FRAME_LEN; i++) begin : g_chain
    if (i == FRAME_LEN - 1) begin : g_tail
      dtfe_byte_cell u_cell (
        .clk_i,
        .ctrl_i      (ctrl),
        .load_byte_i (frame_bytes[i]),
        .next_byte_i (SEP_BYTE),
        .byte_o      (chain_q[i])
      );
    end else begin : g_body
      dtfe_byte_cell u_cell (
        .clk_i,
        .ctrl_i      (ctrl),
        .load_byte_i (frame_bytes[i]),
        .next_byte_i (chain_q[i+1]),
        .byte_o      (chain_q[i])
      );
    end
  end

  assign frame_o.valid      = (cnt_q != '0);
  assign frame_o.frame_byte = chain_q[0];
  assign frame_o.frame_end  = (cnt_q == CNT_W'(1));

endmodule : decimal_telemetry_frame_encoder_core

`default_nettype wire

[hw/rtl/dtfe_checker.sv]
// ----------------------------------------------------------------------------
// dtfe_checker
// Port-level checks of frame structure on the frame channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfe_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [7:0] out_byte_i,
  input wire       out_end_i
);
  import dtfe_pkg::*;

  logic [CNT_W-1:0] pos_d, pos_q;
  logic             fire;

  assign fire  = out_valid_i && out_ready_i;
  assign pos_d = !fire ? pos_q : (out_end_i ? '0 : pos_q + CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
                                    $stable(out_end_i))
    else $error("frame word changed while stalled");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_end_i == (pos_q == CNT_W'(FRAME_LEN - 1))))
    else $error("frame_end not on the last word of a frame");

  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (pos_q == '0) |-> (out_byte_i == HEADER_BYTE))
    else $error("frame does not open with the header");

  a_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((pos_q == CNT_W'(SEP0_POS)) || (pos_q == CNT_W'(SEP1_POS)) ||
                    (pos_q == CNT_W'(SEP2_POS))) |-> (out_byte_i == SEP_BYTE))
    else $error("separator word is not zero");

  a_trail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_end_i |-> (out_byte_i == TRAILER_BYTE))
    else $error("last word is not the trailer");

endmodule : dtfe_checker

bind decimal_telemetry_frame_encoder_core dtfe_checker u_dtfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (frame_o.valid),
  .out_ready_i (frame_o.ready),
  .out_byte_i  (frame_o.frame_byte),
  .out_end_i   (frame_o.frame_end)
);

`default_nettype wire

[verif/dtfe_frame_checker.sv]
// ----------------------------------------------------------------------------
// dtfe_frame_checker
// Watches both channels of the frame encoder and checks every frame word.
// ----------------------------------------------------------------------------
// Each accepted request is turned into the 21 words its frame must contain.
// The words go into an in-order store. Each word taken from the frame channel
// is compared, byte and end flag, with the oldest word in that store.
// ----------------------------------------------------------------------------
module dtfe_frame_checker
  import dtfe_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  dtfe_req_if   req_mon,
  dtfe_frame_if frame_mon,
  output int    mismatch_count_o,
  output int    pending_words_o,
  output int    checked_words_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    byte_t value;
    logic  last;
  } frame_word_t;

  frame_word_t expected_words[$];

  initial begin
    mismatch_count_o = 0;
    pending_words_o  = 0;
    checked_words_o  = 0;
  end

  task automatic push_word(input byte_t value, input logic last);
    frame_word_t w;
    w.value = value;
    w.last  = last;
    expected_words.push_back(w);
  endtask

  task automatic push_two_digits(input byte_t v);
    push_word(byte_t'(v / DIV_10), 1'b0);
    push_word(byte_t'(v % DIV_10), 1'b0);
  endtask

  task automatic push_four_digits(input logic [15:0] v);
    push_word(byte_t'(v / DIV_1000), 1'b0);
    push_word(byte_t'((v / DIV_100) % DIV_10), 1'b0);
    push_word(byte_t'((v / DIV_10) % DIV_10), 1'b0);
    push_word(byte_t'(v % DIV_10), 1'b0);
  endtask

  // The leading digit is the plain quotient, so it may exceed nine.
  task automatic predict_frame(input byte_t hum_whole, input byte_t hum_frac,
                               input byte_t tmp_whole, input byte_t tmp_frac,
                               input logic [15:0] smoke, input logic [15:0] light);
    push_word(HEADER_BYTE, 1'b0);
    push_two_digits(hum_whole);
    push_two_digits(hum_frac);
    push_word(SEP_BYTE, 1'b0);
    push_two_digits(tmp_whole);
    push_two_digits(tmp_frac);
    push_word(SEP_BYTE, 1'b0);
    push_four_digits(smoke);
    push_word(SEP_BYTE, 1'b0);
    push_four_digits(light);
    push_word(TRAILER_BYTE, 1'b1);
  endtask

  task automatic report(input string what, input int expected, input int actual);
    mismatch_count_o = mismatch_count_o + 1;
    $display("%0t: %s mismatch, expected %h, got %h", $realtime, what,
             expected, actual);
  endtask

  always @(posedge clk_i) begin
    frame_word_t want;
    if (rst_ni) begin
      if (frame_mon.valid && frame_mon.ready) begin
        checked_words_o = checked_words_o + 1;
        if (expected_words.size() == 0) begin
          mismatch_count_o = mismatch_count_o + 1;
          $display("%0t: frame word %h with nothing expected, expected none",
                   $realtime, frame_mon.frame_byte);
        end else begin
          want = expected_words.pop_front();
          if (frame_mon.frame_byte !== want.value) begin
            report("frame_byte", want.value, frame_mon.frame_byte);
          end
          if (frame_mon.frame_end !== want.last) begin
            report("frame_end", want.last, frame_mon.frame_end);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_frame(req_mon.humidity_whole, req_mon.humidity_fraction,
                      req_mon.temperature_whole, req_mon.temperature_fraction,
                      req_mon.smoke_level, req_mon.light_level);
      end
      pending_words_o = expected_words.size();
    end
  end

endmodule : dtfe_frame_checker

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the decimal telemetry frame encoder.
// ----------------------------------------------------------------------------
// A short directed set covers the reading extremes and the digit boundaries,
// then random requests follow under three idle mixes on the request and frame
// channels. The checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtfe_pkg::*;

  localparam int RANDOM_PER_PHASE = 120;
  localparam int STALL_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = CONV_LAT + FRAME_LEN + 10;

  logic clk_i;
  logic rst_ni;

  dtfe_req_if   req_ch ();
  dtfe_frame_if frame_ch ();

  int tx_idle_pct;
  int rx_idle_pct;
  int sent_count;
  int directed_count;
  int stall_cycles;
  int mismatch_count;
  int pending_words;
  int checked_words;

  decimal_telemetry_frame_encoder_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .frame_o (frame_ch)
  );

  dtfe_frame_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon          (req_ch),
    .frame_mon        (frame_ch),
    .mismatch_count_o (mismatch_count),
    .pending_words_o  (pending_words),
    .checked_words_o  (checked_words)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Frame receiver: ready is redrawn once per cycle.
  initial begin
    frame_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      frame_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) ||
        (frame_ch.valid && frame_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task automatic send_request(input byte_t hum_whole, input byte_t hum_frac,
                              input byte_t tmp_whole, input byte_t tmp_frac,
                              input logic [15:0] smoke, input logic [15:0] light);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid                <= 1'b1;
    req_ch.humidity_whole       <= hum_whole;
    req_ch.humidity_fraction    <= hum_frac;
    req_ch.temperature_whole    <= tmp_whole;
    req_ch.temperature_fraction <= tmp_frac;
    req_ch.smoke_level          <= smoke;
    req_ch.light_level          <= light;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent_count++;
  endtask

  // Shapes: full range, plausible sensor range, or boundary and end values.
  function automatic byte_t pick_short(input int shape);
    case (shape)
      0: return byte_t'($urandom_range(255));
      1: return byte_t'($urandom_range(99));
      default: begin
        case ($urandom_range(6))
          0: return 8'd0;
          1: return 8'd9;
          2: return 8'd10;
          3: return 8'd99;
          4: return 8'd100;
          5: return 8'd250;
          default: return 8'd255;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_long(input int shape);
    case (shape)
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(9999));
      default: begin
        case ($urandom_range(7))
          0: return 16'd0;
          1: return 16'd999;
          2: return 16'd1000;
          3: return 16'd9999;
          4: return 16'd10000;
          5: return 16'd64999;
          6: return 16'd65000;
          default: return 16'd65535;
        endcase
      end
    endcase
  endfunction

  task automatic send_random(input int count);
    int shape;
    int draw;
    for (int i = 0; i < count; i++) begin
      draw  = $urandom_range(9);
      shape = (draw < 4) ? 0 : (draw < 8) ? 1 : 2;
      send_request(pick_short(shape), pick_short(shape), pick_short(shape),
                   pick_short(shape), pick_long(shape), pick_long(shape));
    end
  endtask

  initial begin
    rst_ni                      = 1'b0;
    req_ch.valid                = 1'b0;
    req_ch.humidity_whole       = '0;
    req_ch.humidity_fraction    = '0;
    req_ch.temperature_whole    = '0;
    req_ch.temperature_fraction = '0;
    req_ch.smoke_level          = '0;
    req_ch.light_level          = '0;
    tx_idle_pct                 = 15;
    rx_idle_pct                 = 66;
    sent_count                  = 0;
    stall_cycles                = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extremes, digit boundaries, alternating bit patterns and mixed values.
    send_request(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    send_request(8'd255, 8'd255, 8'd255, 8'd255, 16'd65535, 16'd65535);
    send_request(8'd99, 8'd99, 8'd99, 8'd99, 16'd9999, 16'd9999);
    send_request(8'd100, 8'd100, 8'd100, 8'd100, 16'd10000, 16'd10000);
    send_request(8'd9, 8'd9, 8'd9, 8'd9, 16'd999, 16'd999);
    send_request(8'd10, 8'd10, 8'd10, 8'd10, 16'd1000, 16'd1000);
    send_request(8'hAA, 8'h55, 8'hAA, 8'h55, 16'hAAAA, 16'h5555);
    send_request(8'h55, 8'hAA, 8'h55, 8'hAA, 16'h5555, 16'hAAAA);
    send_request(8'd1, 8'd1, 8'd1, 8'd1, 16'd1, 16'd1);
    send_request(8'd249, 8'd250, 8'd254, 8'd199, 16'd64999, 16'd65000);
    send_request(8'd45, 8'd67, 8'd23, 8'd5, 16'd1234, 16'd40960);
    send_request(8'd0, 8'd255, 8'd255, 8'd0, 16'd65535, 16'd0);
    directed_count = sent_count;

    send_random(RANDOM_PER_PHASE);

    tx_idle_pct = 66;
    rx_idle_pct = 15;
    send_random(RANDOM_PER_PHASE);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(RANDOM_PER_PHASE);
    req_ch.valid <= 1'b0;

    while (pending_words != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Run covered %0d requests (%0d directed) under three idle mixes.",
             sent_count, directed_count);
    $display("Frame words checked: %0d, mismatches: %0d, still expected: %0d.",
             checked_words, mismatch_count, pending_words);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule : tb_top

[sim.f]
hw/rtl/dtfe_pkg.sv
hw/rtl/dtfe_if.sv
hw/rtl/dtfe_digit_cell.sv
hw/rtl/dtfe_byte_cell.sv
hw/rtl/decimal_telemetry_frame_encoder_core.sv
hw/rtl/dtfe_checker.sv
verif/dtfe_frame_checker.sv
verif/tb_top.sv
